// File: hw/rtl/lavm_pkg.sv
package lavm_pkg;

  // Fixed point format of all ports
  localparam int FRAC_BITS = 16;

  // Normalized vector component: |c| <= 2^FRAC_BITS + 1, signed
  localparam int VEC_W  = FRAC_BITS + 3;
  // Exact cross product of two normalized vectors
  localparam int CW     = 2 * VEC_W + 1;
  // Normalizer input width: covers the 33-bit difference and the cross product
  localparam int NORM_W = (CW > 33) ? CW : 33;
  localparam int SHW    = $clog2(NORM_W);
  // The largest prescaled magnitude lands in [2^TOPB, 2^(TOPB+1))
  localparam int TOPB   = 29;
  // Root bits and quotient bits
  localparam int SQ_STEPS = 31;
  localparam int QW       = FRAC_BITS + 2;
  localparam int NORM_LAT = 4 + SQ_STEPS + QW + 1;
  // Recomputed up component and dot product widths
  localparam int UW     = CW - FRAC_BITS;
  localparam int DOTW   = UW + 34;

  typedef logic signed [NORM_W-1:0] ncomp_t;
  typedef ncomp_t [2:0]             nvec_t;
  typedef logic signed [VEC_W-1:0]  vcomp_t;
  typedef vcomp_t [2:0]             vvec_t;
  typedef logic signed [DOTW-1:0]   wide_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] camup_x;
    logic signed [31:0] camup_y;
    logic signed [31:0] camup_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } res_t;

  // One restoring square root digit
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t a, input int unsigned k);
    logic [63:0] bitv;
    logic [63:0] t;
    sq_t         o;
    bitv = 64'd1 << (2 * k);
    t    = a.r + bitv;
    if (a.x >= t) begin
      o.x = a.x - t;
      o.r = (a.r >> 1) + bitv;
    end else begin
      o.x = a.x;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  // Drop FRAC_BITS fraction bits, round half away from zero
  function automatic wide_t round_frac(input wide_t v);
    logic [DOTW-1:0] m;
    m = v[DOTW-1] ? DOTW'(-v) : DOTW'(v);
    m = (m + (DOTW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[DOTW-1] ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > wide_t'(32'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end else if (v < wide_t'(32'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hw/rtl/lavm_norm.sv
module lavm_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  lavm_pkg::nvec_t vec_i,
  output logic           valid_o,
  output lavm_pkg::vvec_t vec_o
);
  import lavm_pkg::*;

  typedef struct packed {
    logic [2:0][TOPB:0] m;
    logic [2:0]         neg;
    logic               zero;
  } nside_t;

  typedef struct packed {
    logic [2:0][63:0]   rem;
    logic [2:0][QW-1:0] q;
    logic [30:0]        len;
    logic [2:0]         neg;
    logic               zero;
  } dv_t;

  function automatic dv_t div_step(input dv_t a, input int unsigned k);
    dv_t         o;
    logic [63:0] dsh;
    o   = a;
    dsh = 64'(a.len) << k;
    for (int i = 0; i < 3; i++) begin
      if (a.rem[i] >= dsh) begin
        o.rem[i]  = a.rem[i] - dsh;
        o.q[i][k] = 1'b1;
      end
    end
    return o;
  endfunction

  logic [NORM_LAT-1:0] vld_q;

  // Stage A: magnitudes and leading one of the largest
  logic [2:0][NORM_W-1:0] mag;
  logic [NORM_W-1:0]      orv;
  logic [SHW-1:0]         lead;
  logic [2:0][NORM_W-1:0] a_m_q;
  logic [2:0]             a_neg_q;
  logic [SHW-1:0]         a_lead_q;
  logic                   a_zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][NORM_W-1] ? NORM_W'(-vec_i[i]) : NORM_W'(vec_i[i]);
    end
    orv  = mag[0] | mag[1] | mag[2];
    lead = '0;
    for (int b = 0; b < NORM_W; b++) begin
      if (orv[b]) lead = SHW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    a_m_q    <= mag;
    a_lead_q <= lead;
    a_zero_q <= (orv == '0);
    for (int i = 0; i < 3; i++) a_neg_q[i] <= vec_i[i][NORM_W-1];
  end

  // Stage B: common prescale by a power of two
  logic [2:0][NORM_W-1:0] shf;
  logic [2:0][TOPB:0]     b_m_q;
  logic [2:0]             b_neg_q;
  logic                   b_zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (a_lead_q >= SHW'(TOPB)) begin
        shf[i] = a_m_q[i] >> (a_lead_q - SHW'(TOPB));
      end else begin
        shf[i] = a_m_q[i] << (SHW'(TOPB) - a_lead_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) b_m_q[i] <= shf[i][TOPB:0];
    b_neg_q  <= a_neg_q;
    b_zero_q <= a_zero_q;
  end

  // Stage C: squares
  logic [2:0][59:0] c_sq_q;
  nside_t           c_sd_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) c_sq_q[i] <= 60'(b_m_q[i]) * 60'(b_m_q[i]);
    c_sd_q.m    <= b_m_q;
    c_sd_q.neg  <= b_neg_q;
    c_sd_q.zero <= b_zero_q;
  end

  // Stage D and root pipeline: one result bit per stage
  sq_t    sq_q [SQ_STEPS+1];
  nside_t sd_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    sq_q[0].x <= 64'(c_sq_q[0]) + 64'(c_sq_q[1]) + 64'(c_sq_q[2]);
    sq_q[0].r <= '0;
    sd_q[0]   <= c_sd_q;
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      sq_q[j+1] <= sqrt_step(sq_q[j], SQ_STEPS - 1 - j);
      sd_q[j+1] <= sd_q[j];
    end
  end

  // Division pipeline: one quotient bit per stage, three lanes
  dv_t dv_in [QW];
  dv_t dv_q  [QW];

  always_comb begin
    dv_in[0].len  = sq_q[SQ_STEPS].r[30:0];
    dv_in[0].neg  = sd_q[SQ_STEPS].neg;
    dv_in[0].zero = sd_q[SQ_STEPS].zero;
    dv_in[0].q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv_in[0].rem[i] = (64'(sd_q[SQ_STEPS].m[i]) << FRAC_BITS) +
                        64'(sq_q[SQ_STEPS].r[30:1]);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    if (j > 0) begin : g_link
      assign dv_in[j] = dv_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      dv_q[j] <= div_step(dv_in[j], QW - 1 - j);
    end
  end

  // Output: sign and zero vector
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_q[QW-1].zero) begin
        vec_o[i] <= '0;
      end else if (dv_q[QW-1].neg[i]) begin
        vec_o[i] <= -vcomp_t'(dv_q[QW-1].q[i]);
      end else begin
        vec_o[i] <= vcomp_t'(dv_q[QW-1].q[i]);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NORM_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NORM_LAT-1];

  localparam vcomp_t UnitMax = vcomp_t'((1 << FRAC_BITS) + 1);

  a_prescale_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !b_zero_q) |-> (b_m_q[0][TOPB] || b_m_q[1][TOPB] || b_m_q[2][TOPB]))
    else $error("prescale missed the target range");

  a_root_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4+SQ_STEPS-1] && !sd_q[SQ_STEPS].zero) |-> sq_q[SQ_STEPS].r[30:29] != 2'b00)
    else $error("vector length below prescale floor");

  a_unit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (vec_o[0] <= UnitMax && vec_o[0] >= -UnitMax &&
                 vec_o[1] <= UnitMax && vec_o[1] >= -UnitMax &&
                 vec_o[2] <= UnitMax && vec_o[2] >= -UnitMax))
    else $error("normalized component out of range");

endmodule

// File: hw/rtl/look_at_view_matrix.sv
// Look-at view matrix, signed fixed point with FRAC_BITS fraction bits.
//
// Request channel: req_i carries eye, target and up vectors. A request is
// taken at a rising edge where start is high and busy is low. busy is held
// low: the pipeline takes a new request every cycle.
// Result channel: res_o carries the rotation rows (side, camup, back) and
// the translation (shift). valid_o is high for exactly one cycle per result
// and the receiver must take it then; there is no back pressure.
//
// The pipeline length is set by the two normalizers in series, each a one
// bit per stage square root followed by a one bit per stage divider.
// Ports are Q16.16 with FRAC_BITS = 16.
// Throughput: one request per cycle, results in request order.
//
// Reset clears all valid bits; requests in flight are dropped and no
// result appears until new requests have passed the full latency.
module look_at_view_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  lavm_pkg::req_t req_i,
  output logic           busy,
  output logic           valid_o,
  output lavm_pkg::res_t res_o
);
  import lavm_pkg::*;

  localparam int NL = NORM_LAT;

  typedef logic signed [2*VEC_W-1:0] pv_t;
  typedef logic signed [VEC_W+31:0]  pe_t;
  typedef logic signed [UW+31:0]     pu_t;
  typedef logic signed [31:0]        eye_t [3];
  typedef logic signed [UW-1:0]      ucomp_t;

  assign busy = 1'b0;

  // Input register: eye, exact difference, up
  logic               v0_q;
  eye_t               eye_d [2*NL+7];
  logic signed [32:0] d_q [3];
  logic signed [31:0] upi_q [3];
  nvec_t              nf_in, nu_in;

  always_ff @(posedge clk_i) begin
    eye_d[0][0] <= req_i.eye_x;
    eye_d[0][1] <= req_i.eye_y;
    eye_d[0][2] <= req_i.eye_z;
    d_q[0]      <= 33'(req_i.target_x) - 33'(req_i.eye_x);
    d_q[1]      <= 33'(req_i.target_y) - 33'(req_i.eye_y);
    d_q[2]      <= 33'(req_i.target_z) - 33'(req_i.eye_z);
    upi_q[0]    <= req_i.upward_x;
    upi_q[1]    <= req_i.upward_y;
    upi_q[2]    <= req_i.upward_z;
  end

  for (genvar j = 0; j < 2*NL+6; j++) begin : g_eye
    always_ff @(posedge clk_i) eye_d[j+1] <= eye_d[j];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nf_in[i] = NORM_W'(d_q[i]);
      nu_in[i] = NORM_W'(upi_q[i]);
    end
  end

  // Forward and up normalizers
  logic  fv, uv;
  vvec_t f_w, u_w;

  lavm_norm u_norm_f (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q),
    .vec_i  (nf_in),
    .valid_o(fv),
    .vec_o  (f_w)
  );

  lavm_norm u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q),
    .vec_i  (nu_in),
    .valid_o(uv),
    .vec_o  (u_w)
  );

  // Delay lines for f and up past the side normalizer
  vvec_t f_d  [NL+9];
  vvec_t up_d [NL+3];
  assign f_d[0]  = f_w;
  assign up_d[0] = u_w;

  for (genvar j = 1; j < NL+9; j++) begin : g_fd
    always_ff @(posedge clk_i) f_d[j] <= f_d[j-1];
  end
  for (genvar j = 1; j < NL+3; j++) begin : g_ud
    always_ff @(posedge clk_i) up_d[j] <= up_d[j-1];
  end

  // cross(f, up): products, then differences
  logic     x1v_q, x2v_q;
  pv_t      xp_q [6];
  nvec_t    xc_q;

  always_ff @(posedge clk_i) begin
    xp_q[0] <= pv_t'(f_w[1]) * pv_t'(u_w[2]);
    xp_q[1] <= pv_t'(f_w[2]) * pv_t'(u_w[1]);
    xp_q[2] <= pv_t'(f_w[2]) * pv_t'(u_w[0]);
    xp_q[3] <= pv_t'(f_w[0]) * pv_t'(u_w[2]);
    xp_q[4] <= pv_t'(f_w[0]) * pv_t'(u_w[1]);
    xp_q[5] <= pv_t'(f_w[1]) * pv_t'(u_w[0]);
    xc_q[0] <= NORM_W'(xp_q[0]) - NORM_W'(xp_q[1]);
    xc_q[1] <= NORM_W'(xp_q[2]) - NORM_W'(xp_q[3]);
    xc_q[2] <= NORM_W'(xp_q[4]) - NORM_W'(xp_q[5]);
  end

  // Side normalizer
  logic  sv;
  vvec_t s_w;

  lavm_norm u_norm_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(x2v_q),
    .vec_i  (xc_q),
    .valid_o(sv),
    .vec_o  (s_w)
  );

  // Side select: rotated up when f equals up or its negation
  vvec_t fa, ua;
  logic  par;
  vvec_t s_d [6];
  logic  y1v_q;

  assign fa = f_d[NL+2];
  assign ua = up_d[NL+2];

  always_comb begin
    par = ((fa[0] == ua[0]) && (fa[1] == ua[1]) && (fa[2] == ua[2])) ||
          ((fa[0] == -ua[0]) && (fa[1] == -ua[1]) && (fa[2] == -ua[2]));
  end

  always_ff @(posedge clk_i) begin
    if (par) begin
      s_d[0][0] <= ua[2];
      s_d[0][1] <= ua[0];
      s_d[0][2] <= ua[1];
    end else begin
      s_d[0] <= s_w;
    end
  end

  for (genvar j = 1; j < 6; j++) begin : g_sd
    always_ff @(posedge clk_i) s_d[j] <= s_d[j-1];
  end

  // cross(s, f) and dot products with eye: products
  vvec_t fb;
  eye_t  eb;
  logic  y2v_q, y3v_q;
  pv_t   sp_q [6];
  pe_t   ds_q [3];
  pe_t   df_q [3];

  assign fb = f_d[NL+3];
  assign eb = eye_d[2*NL+3];

  always_ff @(posedge clk_i) begin
    sp_q[0] <= pv_t'(s_d[0][1]) * pv_t'(fb[2]);
    sp_q[1] <= pv_t'(s_d[0][2]) * pv_t'(fb[1]);
    sp_q[2] <= pv_t'(s_d[0][2]) * pv_t'(fb[0]);
    sp_q[3] <= pv_t'(s_d[0][0]) * pv_t'(fb[2]);
    sp_q[4] <= pv_t'(s_d[0][0]) * pv_t'(fb[1]);
    sp_q[5] <= pv_t'(s_d[0][1]) * pv_t'(fb[0]);
    for (int i = 0; i < 3; i++) begin
      ds_q[i] <= pe_t'(s_d[0][i]) * pe_t'(eb[i]);
      df_q[i] <= pe_t'(fb[i]) * pe_t'(eb[i]);
    end
  end

  // Sums
  wide_t c2_q [3];
  wide_t dsum_q, fsum_q;

  always_ff @(posedge clk_i) begin
    c2_q[0] <= wide_t'(sp_q[0]) - wide_t'(sp_q[1]);
    c2_q[1] <= wide_t'(sp_q[2]) - wide_t'(sp_q[3]);
    c2_q[2] <= wide_t'(sp_q[4]) - wide_t'(sp_q[5]);
    dsum_q  <= wide_t'(ds_q[0]) + wide_t'(ds_q[1]) + wide_t'(ds_q[2]);
    fsum_q  <= wide_t'(df_q[0]) + wide_t'(df_q[1]) + wide_t'(df_q[2]);
  end

  // Rounding of u and the side and forward dots
  logic   y4v_q, y5v_q, y6v_q;
  ucomp_t u4_q [3];
  ucomp_t u5_q [3];
  ucomp_t u6_q [3];
  wide_t  rs4_q, rs5_q, rs6_q, rf4_q, rf5_q, rf6_q;
  wide_t  cr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) cr[i] = round_frac(c2_q[i]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) u4_q[i] <= cr[i][UW-1:0];
    rs4_q <= round_frac(dsum_q);
    rf4_q <= round_frac(fsum_q);
  end

  // dot(u, eye): products then sum
  pu_t   up_q [3];
  wide_t usum_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) up_q[i] <= pu_t'(u4_q[i]) * pu_t'(eye_d[2*NL+6][i]);
    u5_q   <= u4_q;
    rs5_q  <= rs4_q;
    rf5_q  <= rf4_q;
    usum_q <= wide_t'(up_q[0]) + wide_t'(up_q[1]) + wide_t'(up_q[2]);
    u6_q   <= u5_q;
    rs6_q  <= rs5_q;
    rf6_q  <= rf5_q;
  end

  // Output register
  vvec_t fo;
  assign fo = f_d[NL+8];

  always_ff @(posedge clk_i) begin
    res_o.side_x  <= 32'(s_d[5][0]);
    res_o.side_y  <= 32'(s_d[5][1]);
    res_o.side_z  <= 32'(s_d[5][2]);
    res_o.camup_x <= 32'(u6_q[0]);
    res_o.camup_y <= 32'(u6_q[1]);
    res_o.camup_z <= 32'(u6_q[2]);
    res_o.back_x  <= 32'(-fo[0]);
    res_o.back_y  <= 32'(-fo[1]);
    res_o.back_z  <= 32'(-fo[2]);
    res_o.shift_x <= sat32(-rs6_q);
    res_o.shift_y <= sat32(-round_frac(usum_q));
    res_o.shift_z <= sat32(rf6_q);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      x1v_q   <= 1'b0;
      x2v_q   <= 1'b0;
      y1v_q   <= 1'b0;
      y2v_q   <= 1'b0;
      y3v_q   <= 1'b0;
      y4v_q   <= 1'b0;
      y5v_q   <= 1'b0;
      y6v_q   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v0_q    <= start && !busy;
      x1v_q   <= fv && uv;
      x2v_q   <= x1v_q;
      y1v_q   <= sv;
      y2v_q   <= y1v_q;
      y3v_q   <= y2v_q;
      y4v_q   <= y3v_q;
      y5v_q   <= y4v_q;
      y6v_q   <= y5v_q;
      valid_o <= y6v_q;
    end
  end

  localparam logic signed [31:0] UnitMax = 32'((1 << FRAC_BITS) + 1);

  a_side_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.side_x <= UnitMax && res_o.side_x >= -UnitMax &&
                 res_o.side_y <= UnitMax && res_o.side_y >= -UnitMax &&
                 res_o.side_z <= UnitMax && res_o.side_z >= -UnitMax))
    else $error("side vector exceeds unit length");

  a_back_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.back_x <= UnitMax && res_o.back_x >= -UnitMax &&
                 res_o.back_y <= UnitMax && res_o.back_y >= -UnitMax &&
                 res_o.back_z <= UnitMax && res_o.back_z >= -UnitMax))
    else $error("back vector exceeds unit length");

  a_zero_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.back_x == 0 && res_o.back_y == 0 && res_o.back_z == 0) |->
    (res_o.camup_x == 0 && res_o.camup_y == 0 && res_o.camup_z == 0 &&
     res_o.shift_z == 0))
    else $error("zero forward vector gave nonzero up or depth");

endmodule
